FILE: rtl/core/ppid_pkg.sv
// shared types, codes and helpers for the position pid torque controller
package ppid_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_POSITION = 2'd0;
    localparam logic [1:0] OP_VELOCITY = 2'd1;
    localparam logic [1:0] OP_TORQUE   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_CEILING = 3'd5;

    // register reset values
    localparam logic [31:0]        POSITION_GAIN_RST    = 32'd167772;
    localparam logic [31:0]        INTEGRAL_GAIN_RST    = 32'd0;
    localparam logic [31:0]        DAMPING_GAIN_RST     = 32'd1678;
    localparam logic [30:0]        TORQUE_MAX_RST       = 31'd65536;
    localparam logic signed [31:0] POSITION_FLOOR_RST   = 32'sh8000_0000;
    localparam logic signed [31:0] POSITION_CEILING_RST = 32'sh7fff_ffff;

    // integrator limit, 0.1 in q16.16
    localparam int unsigned INTEG_W = 14;
    localparam logic signed [32:0] INTEG_LIMIT = 33'sd6554;

    // gain product width and fraction bits of a q8.24 gain
    localparam int unsigned PROD_W = 64;
    localparam int unsigned GAIN_FRAC = 24;

    // width wide enough for any sum fed to the saturator
    localparam int unsigned SAT_W = 42;
    localparam logic signed [SAT_W-1:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [SAT_W-1:0] SAT_MIN = -42'sd2147483648;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/position_pid_torque_controller.sv
// top level of the position pid torque controller
//
// one control tick per transfer: the block takes one item every clock cycle while
// m_axis is not stalling and returns one result per item. an input register holds
// the tick and a single pass of logic (setpoint window clamp, position and velocity
// errors, the three gain products, scaling, saturation, integrator update, torque
// limit) feeds the output register, which loads from the input register when the
// output side is free. the integrator, the held torque and the last setpoint
// update as a tick moves into the output register, so back to back ticks see
// each other's updates with no bubble. backpressure from m_axis holds both
// registers together. configuration writes are taken every cycle and are meant
// for when no tick is in flight.
module position_pid_torque_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input ticks
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // target_position, measured_position, measured_velocity, torque_command
    input  logic [127:0]                       s_axis_tdata,
    // operation
    input  logic [1:0]                         s_axis_tuser,
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // torque_out, setpoint_used
    output logic [63:0]                        m_axis_tdata,
    // torque_clipped
    output logic [0:0]                         m_axis_tuser,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    // configuration registers
    logic [31:0]        position_gain_reg;
    logic [31:0]        integral_gain_reg;
    logic [31:0]        damping_gain_reg;
    logic [30:0]        torque_max_reg;
    logic signed [31:0] position_floor_reg;
    logic signed [31:0] position_ceiling_reg;

    // input register
    logic               in_vld_reg;
    logic [1:0]         in_op_reg;
    logic signed [31:0] in_target_reg;
    logic signed [31:0] in_meas_pos_reg;
    logic signed [31:0] in_meas_vel_reg;
    logic signed [31:0] in_cmd_reg;

    // gain products
    logic signed [ppid_pkg::PROD_W-1:0] p_prod;
    logic signed [ppid_pkg::PROD_W-1:0] d_prod;
    logic signed [ppid_pkg::PROD_W-1:0] i_prod;

    // output register
    logic               out_vld_reg;
    logic signed [31:0] out_torque_reg;
    logic signed [31:0] out_sp_reg;
    logic               out_clip_reg;

    // loop state
    logic signed [ppid_pkg::INTEG_W-1:0] integ_reg;
    logic signed [ppid_pkg::INTEG_W-1:0] integ_next;
    logic signed [31:0]                  held_reg;
    logic signed [31:0]                  held_next;
    logic signed [31:0]                  last_sp_reg;
    logic signed [31:0]                  last_sp_next;

    // tick moves from the input register to the output register
    logic adv;
    logic in_xfer;

    assign adv           = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // configuration write port, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_gain_reg    <= ppid_pkg::POSITION_GAIN_RST;
            integral_gain_reg    <= ppid_pkg::INTEGRAL_GAIN_RST;
            damping_gain_reg     <= ppid_pkg::DAMPING_GAIN_RST;
            torque_max_reg       <= ppid_pkg::TORQUE_MAX_RST;
            position_floor_reg   <= ppid_pkg::POSITION_FLOOR_RST;
            position_ceiling_reg <= ppid_pkg::POSITION_CEILING_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ppid_pkg::REG_POSITION_GAIN:    position_gain_reg    <= cfg_data;
                ppid_pkg::REG_INTEGRAL_GAIN:    integral_gain_reg    <= cfg_data;
                ppid_pkg::REG_DAMPING_GAIN:     damping_gain_reg     <= cfg_data;
                ppid_pkg::REG_TORQUE_MAX:       torque_max_reg       <= cfg_data[30:0];
                ppid_pkg::REG_POSITION_FLOOR:   position_floor_reg   <= $signed(cfg_data);
                ppid_pkg::REG_POSITION_CEILING: position_ceiling_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_op_reg       <= s_axis_tuser;
            in_target_reg   <= $signed(s_axis_tdata[31:0]);
            in_meas_pos_reg <= $signed(s_axis_tdata[63:32]);
            in_meas_vel_reg <= $signed(s_axis_tdata[95:64]);
            in_cmd_reg      <= $signed(s_axis_tdata[127:96]);
        end
    end

    // window clamp and errors
    logic signed [31:0] sp_floor;
    logic signed [31:0] sp_clamped;
    logic signed [32:0] pos_diff;
    logic signed [32:0] vel_neg;
    logic signed [31:0] pos_err;
    logic signed [31:0] vel_err;

    always_comb begin
        // floor first, then ceiling, so an inverted window yields the ceiling
        sp_floor   = (in_target_reg < position_floor_reg) ? position_floor_reg : in_target_reg;
        sp_clamped = (sp_floor > position_ceiling_reg) ? position_ceiling_reg : sp_floor;
        pos_diff   = 33'(sp_clamped) - 33'(in_meas_pos_reg);
        vel_neg    = 33'sd0 - 33'(in_meas_vel_reg);
        pos_err    = ppid_pkg::sat32(ppid_pkg::SAT_W'(pos_diff));
        vel_err    = ppid_pkg::sat32(ppid_pkg::SAT_W'(vel_neg));
    end

    ppid_gain_mul u_p_mul (
        .gain (position_gain_reg),
        .x    (pos_err),
        .prod (p_prod)
    );

    ppid_gain_mul u_d_mul (
        .gain (damping_gain_reg),
        .x    (vel_err),
        .prod (d_prod)
    );

    ppid_gain_mul u_i_mul (
        .gain (integral_gain_reg),
        .x    (pos_err),
        .prod (i_prod)
    );

    // scale products, accumulate, update integrator, apply limit
    logic signed [39:0] p_scaled;
    logic signed [39:0] d_scaled;
    logic signed [39:0] i_scaled;
    logic signed [31:0] p_term;
    logic signed [31:0] d_term;
    logic signed [31:0] i_term;
    logic signed [33:0] torque_sum;
    logic signed [32:0] integ_sum;
    logic signed [32:0] integ_clamped;
    logic signed [31:0] limit_pos;
    logic signed [31:0] limit_neg;
    logic signed [31:0] torque_limited;
    logic               clip_next;

    always_comb begin
        // arithmetic shift floors toward minus infinity
        p_scaled = p_prod[ppid_pkg::PROD_W-1:ppid_pkg::GAIN_FRAC];
        d_scaled = d_prod[ppid_pkg::PROD_W-1:ppid_pkg::GAIN_FRAC];
        i_scaled = i_prod[ppid_pkg::PROD_W-1:ppid_pkg::GAIN_FRAC];
        p_term   = ppid_pkg::sat32(ppid_pkg::SAT_W'(p_scaled));
        d_term   = ppid_pkg::sat32(ppid_pkg::SAT_W'(d_scaled));
        i_term   = ppid_pkg::sat32(ppid_pkg::SAT_W'(i_scaled));

        // torque uses the integrator from before this tick
        torque_sum = 34'(p_term) + 34'(d_term) + 34'(integ_reg);

        integ_sum = 33'(integ_reg) + 33'(i_term);
        if (integ_sum > ppid_pkg::INTEG_LIMIT) begin
            integ_clamped = ppid_pkg::INTEG_LIMIT;
        end else if (integ_sum < -ppid_pkg::INTEG_LIMIT) begin
            integ_clamped = -ppid_pkg::INTEG_LIMIT;
        end else begin
            integ_clamped = integ_sum;
        end

        integ_next   = integ_reg;
        held_next    = held_reg;
        last_sp_next = last_sp_reg;
        case (in_op_reg)
            ppid_pkg::OP_POSITION: begin
                integ_next   = integ_clamped[ppid_pkg::INTEG_W-1:0];
                held_next    = ppid_pkg::sat32(ppid_pkg::SAT_W'(torque_sum));
                last_sp_next = sp_clamped;
            end
            ppid_pkg::OP_TORQUE: begin
                held_next = in_cmd_reg;
            end
            ppid_pkg::OP_VELOCITY: ;
            // unused code holds like velocity mode
            default: ;
        endcase

        // symmetric torque limit
        limit_pos = $signed({1'b0, torque_max_reg});
        limit_neg = -limit_pos;
        clip_next = 1'b0;
        if (held_next > limit_pos) begin
            torque_limited = limit_pos;
            clip_next      = 1'b1;
        end else if (held_next < limit_neg) begin
            torque_limited = limit_neg;
            clip_next      = 1'b1;
        end else begin
            torque_limited = held_next;
        end
    end

    // loop state advances once per tick as it enters the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg   <= '0;
            held_reg    <= '0;
            last_sp_reg <= '0;
        end else if (adv) begin
            integ_reg   <= integ_next;
            held_reg    <= held_next;
            last_sp_reg <= last_sp_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_axis_tready) begin
            out_vld_reg <= adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_torque_reg <= torque_limited;
            out_sp_reg     <= last_sp_next;
            out_clip_reg   <= clip_next;
        end
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = {out_sp_reg, out_torque_reg};
    assign m_axis_tuser[0] = out_clip_reg;

endmodule

FILE: rtl/core/ppid_gain_mul.sv
// multiply of an unsigned q8.24 gain by a signed q16.16 signal
module ppid_gain_mul (
    input  logic [31:0]                         gain,
    input  logic signed [31:0]                  x,
    output logic signed [ppid_pkg::PROD_W-1:0]  prod
);

    logic signed [32:0] gain_s;

    // exact product, magnitude stays below 2^63
    assign gain_s = $signed({1'b0, gain});
    assign prod   = ppid_pkg::PROD_W'(gain_s) * ppid_pkg::PROD_W'(x);

endmodule

FILE: rtl/core/ppid_checker.sv
// port level checks for the position pid torque controller
module ppid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // with the output register empty, nothing can block the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // an input transfer into an empty block shows no result at the next edge
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && s_axis_tvalid && s_axis_tready
            && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind position_pid_torque_controller ppid_checker u_ppid_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
